// File: sv/bdq_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package bdq_pkg;

  // Field widths
  localparam int OP_W   = 3;
  localparam int DATA_W = 32;
  localparam int ST_W   = 2;

  // Default store depth
  localparam int BDQ_DEPTH = 32;

  // Opcodes
  localparam logic [OP_W-1:0] OP_DISPLAY    = 3'd0;
  localparam logic [OP_W-1:0] OP_PUSH_BACK  = 3'd1;
  localparam logic [OP_W-1:0] OP_PUSH_FRONT = 3'd2;
  localparam logic [OP_W-1:0] OP_POP_BACK   = 3'd3;
  localparam logic [OP_W-1:0] OP_POP_FRONT  = 3'd4;

  // Result status codes
  localparam logic [ST_W-1:0] ST_OK    = 2'd0;
  localparam logic [ST_W-1:0] ST_EMPTY = 2'd1;
  localparam logic [ST_W-1:0] ST_FULL  = 2'd2;

  // Commands from controller to datapath
  typedef struct packed {
    logic            start;  // execute a newly accepted item
    logic [OP_W-1:0] op;     // opcode of that item
    logic            load;   // load the output register
    logic            adv;    // step the display walk to the next entry
  } bdq_cmd_t;

endpackage

`default_nettype wire

// File: sv/bounded_deque_with_dump.sv
`timescale 1ns / 1ps
`default_nettype none

// Channel   Dir  Handshake          Payload
// s_*       in   s_tvalid/s_tready  s_tuser opcode, s_tdata value
// m_*       out  m_tvalid/m_tready  m_tuser status, m_tdata value_res, m_tlast last
//
// Push and pop accept the item, then load the output register after the
// registered store read. Display reads one entry per cycle through the single
// store read port, unless the output stalls; an empty display gives one result.
// Synchronous reset empties the store; entry contents are not cleared.
// A stalled output holds the controller in its emit state; input is taken
// only between items. Opcodes 5 to 7 are accepted and dropped.

module bounded_deque_with_dump
  import bdq_pkg::*;
#(
  parameter int DEPTH = BDQ_DEPTH
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              s_tvalid,
  output logic              s_tready,
  input  logic [DATA_W-1:0] s_tdata,   // [31:0] value
  input  logic [OP_W-1:0]   s_tuser,   // [2:0] opcode
  output logic              m_tvalid,
  input  logic              m_tready,
  output logic [DATA_W-1:0] m_tdata,   // [31:0] value_res
  output logic [ST_W-1:0]   m_tuser,   // [1:0] status
  output logic              m_tlast
);

  bdq_cmd_t cmd;
  logic     res_last;

  bdq_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_op     (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .res_last (res_last),
    .cmd      (cmd)
  );

  bdq_dp #(
    .DEPTH (DEPTH)
  ) u_dp (
    .clk        (clk),
    .rst        (rst),
    .cmd        (cmd),
    .in_value   (s_tdata),
    .res_last   (res_last),
    .out_status (m_tuser),
    .out_value  (m_tdata),
    .out_last   (m_tlast)
  );

endmodule

`default_nettype wire

// File: sv/bdq_ctrl.sv
`timescale 1ns / 1ps
`default_nettype none

module bdq_ctrl
  import bdq_pkg::*;
(
  input  logic            clk,
  input  logic            rst,
  input  logic            s_tvalid,
  output logic            s_tready,
  input  logic [OP_W-1:0] s_op,
  output logic            m_tvalid,
  input  logic            m_tready,
  input  logic            res_last,
  output bdq_cmd_t        cmd
);

  typedef enum logic {S_IDLE, S_EMIT} state_t;

  state_t state;
  logic   op_ok;
  logic   out_free;

  // Accept items only in the idle state, between items
  assign s_tready = (state == S_IDLE);
  assign op_ok    = (s_op <= OP_POP_FRONT);
  assign out_free = !m_tvalid || m_tready;

  // Issue commands
  always_comb begin
    cmd.op    = s_op;
    cmd.start = (state == S_IDLE) && s_tvalid && op_ok;
    cmd.load  = (state == S_EMIT) && out_free;
    cmd.adv   = cmd.load && !res_last;
  end

  // Hold state and output valid
  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_IDLE;
      m_tvalid <= 1'b0;
    end else begin
      unique case (state)
        S_IDLE: begin
          if (cmd.start) state <= S_EMIT;
        end
        S_EMIT: begin
          if (cmd.load && res_last) state <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
      if (cmd.load) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
    end
  end

  // Every executed item enters the emit state to produce its results
  a_start_emit: assert property (@(posedge clk) disable iff (rst)
    cmd.start |=> (state == S_EMIT))
    else $error("start did not enter emit");

  // A load always presents a result next cycle
  a_load_valid: assert property (@(posedge clk) disable iff (rst)
    cmd.load |=> m_tvalid)
    else $error("loaded result not presented");

  // No load while a presented result is stalled
  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && !m_tready) |-> !cmd.load)
    else $error("result overwritten while stalled");

endmodule

`default_nettype wire

// File: sv/bdq_dp.sv
`timescale 1ns / 1ps
`default_nettype none

module bdq_dp
  import bdq_pkg::*;
#(
  parameter int DEPTH = BDQ_DEPTH
) (
  input  logic              clk,
  input  logic              rst,
  input  bdq_cmd_t          cmd,
  input  logic [DATA_W-1:0] in_value,
  output logic              res_last,
  output logic [ST_W-1:0]   out_status,
  output logic [DATA_W-1:0] out_value,
  output logic              out_last
);

  localparam int IW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  logic [DATA_W-1:0] mem [DEPTH];
  logic [DATA_W-1:0] rd_data;

  logic [IW-1:0]     front;
  logic [IW-1:0]     front_next;
  logic [CW-1:0]     count;
  logic [CW-1:0]     count_next;
  logic [CW-1:0]     walk;
  logic [CW-1:0]     walk_inc;
  logic              disp_q;
  logic              use_rd;
  logic              use_rd_next;
  logic [ST_W-1:0]   status_q;
  logic [ST_W-1:0]   status_next;

  logic              empty;
  logic              full;
  logic [IW-1:0]     front_dec;
  logic [IW-1:0]     front_inc;
  logic              wr_en;
  logic [IW-1:0]     wr_addr;
  logic              rd_en;
  logic [IW-1:0]     rd_addr;

  // Ring slot at an offset from the front; for offsets up to the depth the sum stays below twice the depth
  function automatic logic [IW-1:0] slot(input logic [IW-1:0] base,
                                         input logic [CW-1:0] off);
    logic [CW:0] sum;
    sum = {{(CW + 1 - IW){1'b0}}, base} + {1'b0, off};
    if (sum >= (CW + 1)'(DEPTH)) sum = sum - (CW + 1)'(DEPTH);
    return sum[IW-1:0];
  endfunction

  assign empty     = (count == '0);
  assign full      = (count == CW'(DEPTH));
  assign front_dec = (front == '0) ? IW'(DEPTH - 1) : front - 1'b1;
  assign front_inc = (front == IW'(DEPTH - 1)) ? '0 : front + 1'b1;
  assign walk_inc  = walk + 1'b1;

  // Decode the operation into memory accesses and pointer updates
  always_comb begin
    wr_en       = 1'b0;
    wr_addr     = front;
    rd_en       = 1'b0;
    rd_addr     = front;
    front_next  = front;
    count_next  = count;
    status_next = status_q;
    use_rd_next = use_rd;
    if (cmd.start) begin
      status_next = ST_OK;
      use_rd_next = 1'b0;
      unique case (cmd.op)
        OP_DISPLAY: begin
          rd_en       = !empty;
          status_next = empty ? ST_EMPTY : ST_OK;
          use_rd_next = !empty;
        end
        OP_PUSH_BACK: begin
          wr_addr = slot(front, count);
          if (full) begin
            status_next = ST_FULL;
          end else begin
            wr_en      = 1'b1;
            count_next = count + 1'b1;
          end
        end
        OP_PUSH_FRONT: begin
          wr_addr = front_dec;
          if (full) begin
            status_next = ST_FULL;
          end else begin
            wr_en      = 1'b1;
            front_next = front_dec;
            count_next = count + 1'b1;
          end
        end
        OP_POP_BACK: begin
          rd_addr = slot(front, count - 1'b1);
          if (empty) begin
            status_next = ST_EMPTY;
          end else begin
            rd_en       = 1'b1;
            use_rd_next = 1'b1;
            count_next  = count - 1'b1;
          end
        end
        OP_POP_FRONT: begin
          if (empty) begin
            status_next = ST_EMPTY;
          end else begin
            rd_en       = 1'b1;
            use_rd_next = 1'b1;
            front_next  = front_inc;
            count_next  = count - 1'b1;
          end
        end
        default: begin
          status_next = status_q;
        end
      endcase
    end else if (cmd.adv) begin
      rd_en   = 1'b1;
      rd_addr = slot(front, walk_inc);
    end
  end

  // Store: one write port, one registered read port
  always_ff @(posedge clk) begin
    if (wr_en) mem[wr_addr] <= in_value;
    if (rd_en) rd_data <= mem[rd_addr];
  end

  // Hold ring pointers
  always_ff @(posedge clk) begin
    if (rst) begin
      front <= '0;
      count <= '0;
    end else begin
      front <= front_next;
      count <= count_next;
    end
  end

  // Hold per-item result context and display walk position
  always_ff @(posedge clk) begin
    status_q <= status_next;
    use_rd   <= use_rd_next;
    if (cmd.start) begin
      disp_q <= (cmd.op == OP_DISPLAY);
      walk   <= '0;
    end else if (cmd.adv) begin
      walk <= walk_inc;
    end
  end

  // Final result of the item: any non-display, an empty display, or the last entry
  assign res_last = !disp_q || (status_q != ST_OK) || (walk_inc == count);

  // Load the output register
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      out_status <= status_q;
      out_value  <= use_rd ? rd_data : '0;
      out_last   <= res_last;
    end
  end

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= CW'(DEPTH))
    else $error("entry count above depth");

  a_front_bound: assert property (@(posedge clk) disable iff (rst)
    front <= IW'(DEPTH - 1))
    else $error("front index out of ring");

  a_push_grows: assert property (@(posedge clk) disable iff (rst)
    (cmd.start && !full && (cmd.op == OP_PUSH_BACK || cmd.op == OP_PUSH_FRONT))
      |=> (count == $past(count) + 1'b1))
    else $error("push did not grow the store");

endmodule

`default_nettype wire
